// File: rtl/core/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for the heater thermostat controller
// Payload structs, configuration register map, reset values and beep timing.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int unsigned SW_W     = 12;
  localparam int unsigned TEMP_W   = 8;
  localparam int unsigned MARGIN_W = 5;
  localparam int unsigned DEB_W    = 4;
  localparam int unsigned BEEP_W   = 13;
  localparam int unsigned START_W  = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [BEEP_W-1:0]  LONG_BEEP_TICKS   = BEEP_W'(5000);
  localparam logic [BEEP_W-1:0]  MID_BEEP_TICKS    = BEEP_W'(2000);
  localparam logic [BEEP_W-1:0]  SHORT_BEEP_TICKS  = BEEP_W'(500);
  localparam logic [START_W-1:0] START_DELAY_TICKS = START_W'(1000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SW_HIGH     = 3'd0,
    REG_SW_MID      = 3'd1,
    REG_TGT_LOW     = 3'd2,
    REG_TGT_MID     = 3'd3,
    REG_TGT_HIGH    = 3'd4,
    REG_OFF_MARGIN  = 3'd5,
    REG_RHT_MARGIN  = 3'd6,
    REG_DEB_LIMIT   = 3'd7
  } htc_reg_t;

  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_MID  = 2'd1,
    LVL_HIGH = 2'd2
  } htc_level_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_HEATING = 2'd1,
    ST_REHEAT  = 2'd2,
    ST_DONE    = 2'd3
  } htc_state_t;

  // alarm flag bit positions
  localparam int unsigned ALM_SHORT = 0;
  localparam int unsigned ALM_MID   = 1;
  localparam int unsigned ALM_LONG  = 2;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [SW_W-1:0]   switch_reading;
  } htc_in_t;

  typedef struct packed {
    logic       relay_on;
    logic       green_led;
    logic       buzzer_on;
    logic [1:0] target_level;
    logic [1:0] heat_state;
    logic       heater_status;
  } htc_out_t;

  typedef struct packed {
    logic [SW_W-1:0]     switch_high_threshold;
    logic [SW_W-1:0]     switch_mid_threshold;
    logic [TEMP_W-1:0]   target_low;
    logic [TEMP_W-1:0]   target_mid;
    logic [TEMP_W-1:0]   target_high;
    logic [MARGIN_W-1:0] off_margin;
    logic [MARGIN_W-1:0] reheat_margin;
    logic [DEB_W-1:0]    debounce_limit;
  } htc_cfg_t;

  localparam htc_cfg_t CFG_RESET = '{
    switch_high_threshold: SW_W'(2596),
    switch_mid_threshold:  SW_W'(1096),
    target_low:            TEMP_W'(20),
    target_mid:            TEMP_W'(30),
    target_high:           TEMP_W'(38),
    off_margin:            MARGIN_W'(2),
    reheat_margin:         MARGIN_W'(5),
    debounce_limit:        DEB_W'(5)
  };

  typedef struct packed {
    logic [1:0]         last_level;
    logic [START_W-1:0] startup_ticks;
    htc_state_t         machine_state;
    logic               heater_flag;
    logic               relay_reg;
    logic               green_reg;
    logic [DEB_W-1:0]   idle_debounce;
    logic [DEB_W-1:0]   heat_debounce;
    logic [DEB_W-1:0]   reheat_on_debounce;
    logic [DEB_W-1:0]   reheat_off_debounce;
    logic [2:0]         alarm_flags;
    logic [BEEP_W-1:0]  beep_ticks;
  } htc_ctx_t;

  typedef struct packed {
    logic             fire;
    logic [DEB_W-1:0] cnt;
  } htc_qual_t;

  // debounce step: a qualifying tick with the count at the limit fires
  function automatic htc_qual_t qualify(input logic cond, input logic [DEB_W-1:0] cnt,
                                        input logic [DEB_W-1:0] limit);
    htc_qual_t q;
    q.fire = 1'b0;
    q.cnt  = '0;
    if (cond) begin
      if (cnt >= limit) begin
        q.fire = 1'b1;
      end else begin
        q.cnt = cnt + DEB_W'(1);
      end
    end
    return q;
  endfunction

endpackage

// File: rtl/core/htc_step.sv
// ----------------------------------------------------------------------------
// htc_step: next-state and result logic for one tick
// Level select, startup delay, heater machine with debounce, beep timer.
// ----------------------------------------------------------------------------
module htc_step (
  input  htc_pkg::htc_cfg_t cfg,
  input  htc_pkg::htc_ctx_t ctx,
  input  htc_pkg::htc_in_t  item,
  output htc_pkg::htc_ctx_t ctx_next,
  output htc_pkg::htc_out_t result
);
  import htc_pkg::*;

  logic [1:0]          level;
  logic [TEMP_W-1:0]   target;
  logic [TEMP_W:0]     off_point;   // target + off margin
  logic [TEMP_W:0]     reheat_sum;  // temperature + reheat margin
  logic                run;
  htc_qual_t           q;
  logic                buzz;
  logic [BEEP_W-1:0]   limit;
  logic [BEEP_W-1:0]   beep_inc;
  logic [1:0]          bit_sel;
  logic                have_beep;

  always_comb begin
    ctx_next = ctx;
    q        = '0;
    buzz     = 1'b0;
    limit    = '0;
    bit_sel  = 2'(ALM_SHORT);
    have_beep = 1'b0;

    // level select, high test first
    if (item.switch_reading >= cfg.switch_high_threshold) begin
      level = LVL_HIGH;
    end else if (item.switch_reading >= cfg.switch_mid_threshold) begin
      level = LVL_MID;
    end else begin
      level = LVL_LOW;
    end
    if (level != ctx.last_level) begin
      ctx_next.alarm_flags[ALM_SHORT] = 1'b1;
      ctx_next.last_level = level;
    end
    unique case (level)
      LVL_HIGH: target = cfg.target_high;
      LVL_MID:  target = cfg.target_mid;
      default:  target = cfg.target_low;
    endcase

    off_point  = {1'b0, target} + (TEMP_W+1)'(cfg.off_margin);
    reheat_sum = {1'b0, item.temperature} + (TEMP_W+1)'(cfg.reheat_margin);

    // startup delay saturates at the limit
    if (ctx.startup_ticks < START_DELAY_TICKS) begin
      ctx_next.startup_ticks = ctx.startup_ticks + START_W'(1);
    end
    run = (ctx_next.startup_ticks >= START_DELAY_TICKS);

    if (run) begin
      unique case (ctx.machine_state)
        ST_IDLE: begin
          if (item.temperature <= target) begin
            q = qualify(1'b1, ctx.idle_debounce, cfg.debounce_limit);
            ctx_next.idle_debounce = q.cnt;
            if (q.fire) begin
              ctx_next.heater_flag   = 1'b1;
              ctx_next.alarm_flags[ALM_MID] = 1'b1;
              ctx_next.machine_state = ST_HEATING;
              ctx_next.relay_reg     = 1'b1;
              ctx_next.green_reg     = 1'b0;
            end
          end else begin
            ctx_next.idle_debounce = '0;
            ctx_next.relay_reg     = 1'b0;
            ctx_next.green_reg     = 1'b1;
          end
        end
        ST_HEATING: begin
          q = qualify({1'b0, item.temperature} >= off_point, ctx.heat_debounce,
                      cfg.debounce_limit);
          ctx_next.heat_debounce = q.cnt;
          if (q.fire) begin
            ctx_next.heater_flag   = 1'b0;
            ctx_next.machine_state = ST_REHEAT;
            ctx_next.relay_reg     = 1'b0;
            ctx_next.green_reg     = 1'b1;
            ctx_next.alarm_flags[ALM_LONG] = 1'b1;
          end
        end
        ST_REHEAT: begin
          if (!ctx.heater_flag) begin
            q = qualify(reheat_sum <= {1'b0, target}, ctx.reheat_on_debounce,
                        cfg.debounce_limit);
            ctx_next.reheat_on_debounce = q.cnt;
            if (q.fire) begin
              ctx_next.heater_flag = 1'b1;
              ctx_next.alarm_flags[ALM_MID] = 1'b1;
              ctx_next.relay_reg   = 1'b1;
              ctx_next.green_reg   = 1'b0;
            end
          end else begin
            q = qualify({1'b0, item.temperature} >= off_point, ctx.reheat_off_debounce,
                        cfg.debounce_limit);
            ctx_next.reheat_off_debounce = q.cnt;
            if (q.fire) begin
              ctx_next.heater_flag = 1'b0;
              ctx_next.relay_reg   = 1'b0;
              ctx_next.green_reg   = 1'b1;
              ctx_next.alarm_flags[ALM_SHORT] = 1'b1;
            end
          end
        end
        default: begin
          // done: hold everything
        end
      endcase
    end

    // beep timer, priority long, mid, short
    priority if (ctx_next.alarm_flags[ALM_LONG]) begin
      bit_sel = 2'(ALM_LONG);  limit = LONG_BEEP_TICKS;  have_beep = 1'b1;
    end else if (ctx_next.alarm_flags[ALM_MID]) begin
      bit_sel = 2'(ALM_MID);   limit = MID_BEEP_TICKS;   have_beep = 1'b1;
    end else if (ctx_next.alarm_flags[ALM_SHORT]) begin
      bit_sel = 2'(ALM_SHORT); limit = SHORT_BEEP_TICKS; have_beep = 1'b1;
    end else begin
      have_beep = 1'b0;
    end
    beep_inc = ctx.beep_ticks + BEEP_W'(1);
    if (have_beep) begin
      if (beep_inc >= limit) begin
        ctx_next.beep_ticks = '0;
        ctx_next.alarm_flags[bit_sel] = 1'b0;
      end else begin
        ctx_next.beep_ticks = beep_inc;
        buzz = 1'b1;
      end
    end

    result.relay_on      = ctx_next.relay_reg;
    result.green_led     = ctx_next.green_reg;
    result.buzzer_on     = buzz;
    result.target_level  = level;
    result.heat_state    = ctx_next.machine_state;
    result.heater_status = ctx_next.heater_flag;
  end

endmodule

// File: rtl/core/heater_thermostat_controller_core.sv
// ----------------------------------------------------------------------------
// heater_thermostat_controller_core: bang-bang heater thermostat, one tick/item
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle; the tick logic settles in one pass ahead
// of the result register, and input is taken whenever that register is free
// or being drained in the same cycle.
// Reset: synchronous, active high; state cleared, registers to defaults.
// ----------------------------------------------------------------------------
module heater_thermostat_controller_core (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration writes
  input  logic                                    cfg_write,
  input  logic [htc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [htc_pkg::CFG_DATA_W-1:0]          cfg_data,
  // tick input
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  htc_pkg::htc_in_t                        in_data,
  // result output
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output htc_pkg::htc_out_t                       out_data
);
  import htc_pkg::*;

  htc_cfg_t cfg;
  htc_ctx_t ctx;
  htc_ctx_t ctx_next;
  htc_out_t result;
  logic     in_xfer;

  // Take a new tick when the result slot is empty or empties this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (htc_reg_t'(cfg_index))
        REG_SW_HIGH:    cfg.switch_high_threshold <= cfg_data[SW_W-1:0];
        REG_SW_MID:     cfg.switch_mid_threshold  <= cfg_data[SW_W-1:0];
        REG_TGT_LOW:    cfg.target_low            <= cfg_data[TEMP_W-1:0];
        REG_TGT_MID:    cfg.target_mid            <= cfg_data[TEMP_W-1:0];
        REG_TGT_HIGH:   cfg.target_high           <= cfg_data[TEMP_W-1:0];
        REG_OFF_MARGIN: cfg.off_margin            <= cfg_data[MARGIN_W-1:0];
        REG_RHT_MARGIN: cfg.reheat_margin         <= cfg_data[MARGIN_W-1:0];
        REG_DEB_LIMIT:  cfg.debounce_limit        <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // All tick work: level, startup, heater machine, beep timer.
  htc_step u_step (
    .cfg      (cfg),
    .ctx      (ctx),
    .item     (in_data),
    .ctx_next (ctx_next),
    .result   (result)
  );

  // Controller state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else if (in_xfer) begin
      ctx <= ctx_next;
    end
  end

  // Result register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= result;
    end
  end

endmodule

// File: rtl/core/htc_checker.sv
// ----------------------------------------------------------------------------
// htc_checker: port-level checks for the heater thermostat controller
// Watches handshake and result consistency; bound onto the core.
// ----------------------------------------------------------------------------
module htc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input htc_pkg::htc_out_t out_data
);
  import htc_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only backs up behind a pending result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result slot");

  // relay drive tracks heater flag
  a_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.relay_on == out_data.heater_status)
    else $error("relay and heater status disagree");

  a_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.relay_on && out_data.green_led))
    else $error("green led on with relay energized");

  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.target_level != 2'd3 && out_data.heat_state != ST_DONE)
    else $error("invalid level or done state reported");

endmodule

bind heater_thermostat_controller_core htc_checker u_htc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/htc_result_checker.sv
// ----------------------------------------------------------------------------
// htc_result_checker: thermostat tick predictor and result comparator
// Watches config writes, input transfers and result transfers of the core,
// runs its own model of one tick per accepted input, and checks every result
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module htc_result_checker
  import htc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  htc_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  htc_out_t              out_data,
  output int                    fails,
  output int                    pending
);

  // model copy of the register file and controller state
  htc_cfg_t          regs;
  htc_level_t        prev_level;
  logic [START_W-1:0] warmup;
  htc_state_t        phase_st;
  logic              heat_on;
  logic              relay;
  logic              green;
  logic [DEB_W-1:0]  idle_cnt;
  logic [DEB_W-1:0]  heat_cnt;
  logic [DEB_W-1:0]  reheat_on_cnt;
  logic [DEB_W-1:0]  reheat_off_cnt;
  logic [2:0]        alarms;
  logic [BEEP_W-1:0] beep_cnt;

  htc_out_t due_results[$];
  htc_out_t want;

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic log_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    fails++;
  endtask

  // {fire, next count}
  function automatic logic [DEB_W:0] debounce(input logic cond, input logic [DEB_W-1:0] cnt);
    if (!cond) return {1'b0, {DEB_W{1'b0}}};
    if (cnt >= regs.debounce_limit) return {1'b1, {DEB_W{1'b0}}};
    return {1'b0, cnt + 1'b1};
  endfunction

  function automatic htc_out_t thermostat_tick(input htc_in_t tick);
    htc_out_t          r;
    htc_level_t        lvl;
    logic [TEMP_W-1:0] tgt;
    logic [TEMP_W:0]   off_point;
    logic [TEMP_W:0]   temp_plus;
    logic [DEB_W:0]    d;
    logic [BEEP_W-1:0] limit;
    logic [1:0]        sel;
    logic              buzz;

    if (tick.switch_reading >= regs.switch_high_threshold) lvl = LVL_HIGH;
    else if (tick.switch_reading >= regs.switch_mid_threshold) lvl = LVL_MID;
    else lvl = LVL_LOW;
    if (lvl != prev_level) begin
      alarms[ALM_SHORT] = 1'b1;
      prev_level = lvl;
    end
    case (lvl)
      LVL_HIGH: tgt = regs.target_high;
      LVL_MID:  tgt = regs.target_mid;
      default:  tgt = regs.target_low;
    endcase
    // one extra bit so the margin sums never wrap
    off_point = {1'b0, tgt} + regs.off_margin;
    temp_plus = {1'b0, tick.temperature} + regs.reheat_margin;

    if (warmup < START_DELAY_TICKS) warmup = warmup + 1'b1;
    if (warmup >= START_DELAY_TICKS) begin
      case (phase_st)
        ST_IDLE: begin
          if (tick.temperature <= tgt) begin
            d = debounce(1'b1, idle_cnt);
            idle_cnt = d[DEB_W-1:0];
            if (d[DEB_W]) begin
              heat_on = 1'b1;
              alarms[ALM_MID] = 1'b1;
              phase_st = ST_HEATING;
              relay = 1'b1;
              green = 1'b0;
            end
          end else begin
            idle_cnt = '0;
            relay = 1'b0;
            green = 1'b1;
          end
        end
        ST_HEATING: begin
          d = debounce({1'b0, tick.temperature} >= off_point, heat_cnt);
          heat_cnt = d[DEB_W-1:0];
          if (d[DEB_W]) begin
            heat_on = 1'b0;
            phase_st = ST_REHEAT;
            relay = 1'b0;
            green = 1'b1;
            alarms[ALM_LONG] = 1'b1;
          end
        end
        ST_REHEAT: begin
          if (!heat_on) begin
            d = debounce(temp_plus <= {1'b0, tgt}, reheat_on_cnt);
            reheat_on_cnt = d[DEB_W-1:0];
            if (d[DEB_W]) begin
              heat_on = 1'b1;
              alarms[ALM_MID] = 1'b1;
              relay = 1'b1;
              green = 1'b0;
            end
          end else begin
            d = debounce({1'b0, tick.temperature} >= off_point, reheat_off_cnt);
            reheat_off_cnt = d[DEB_W-1:0];
            if (d[DEB_W]) begin
              heat_on = 1'b0;
              relay = 1'b0;
              green = 1'b1;
              alarms[ALM_SHORT] = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // shared beep timer, long over mid over short
    buzz = 1'b0;
    if (alarms != 3'b000) begin
      if (alarms[ALM_LONG]) begin
        sel = 2'(ALM_LONG);
        limit = LONG_BEEP_TICKS;
      end else if (alarms[ALM_MID]) begin
        sel = 2'(ALM_MID);
        limit = MID_BEEP_TICKS;
      end else begin
        sel = 2'(ALM_SHORT);
        limit = SHORT_BEEP_TICKS;
      end
      beep_cnt = beep_cnt + 1'b1;
      if (beep_cnt >= limit) begin
        beep_cnt = '0;
        alarms[sel] = 1'b0;
      end else begin
        buzz = 1'b1;
      end
    end

    r.relay_on      = relay;
    r.green_led     = green;
    r.buzzer_on     = buzz;
    r.target_level  = lvl;
    r.heat_state    = phase_st;
    r.heater_status = heat_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs           = CFG_RESET;
      prev_level     = LVL_LOW;
      warmup         = '0;
      phase_st       = ST_IDLE;
      heat_on        = 1'b0;
      relay          = 1'b0;
      green          = 1'b0;
      idle_cnt       = '0;
      heat_cnt       = '0;
      reheat_on_cnt  = '0;
      reheat_off_cnt = '0;
      alarms         = '0;
      beep_cnt       = '0;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        case (htc_reg_t'(cfg_index))
          REG_SW_HIGH:    regs.switch_high_threshold = cfg_data[SW_W-1:0];
          REG_SW_MID:     regs.switch_mid_threshold  = cfg_data[SW_W-1:0];
          REG_TGT_LOW:    regs.target_low            = cfg_data[TEMP_W-1:0];
          REG_TGT_MID:    regs.target_mid            = cfg_data[TEMP_W-1:0];
          REG_TGT_HIGH:   regs.target_high           = cfg_data[TEMP_W-1:0];
          REG_OFF_MARGIN: regs.off_margin            = cfg_data[MARGIN_W-1:0];
          REG_RHT_MARGIN: regs.reheat_margin         = cfg_data[MARGIN_W-1:0];
          REG_DEB_LIMIT:  regs.debounce_limit        = cfg_data[DEB_W-1:0];
          default: ;
        endcase
      end
      // a result at this edge is always from an earlier transfer: check first
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          log_mismatch("unexpected result", int'(out_data), 0);
        end else begin
          want = due_results.pop_front();
          if (out_data.relay_on !== want.relay_on)
            log_mismatch("relay_on", int'(out_data.relay_on), int'(want.relay_on));
          if (out_data.green_led !== want.green_led)
            log_mismatch("green_led", int'(out_data.green_led), int'(want.green_led));
          if (out_data.buzzer_on !== want.buzzer_on)
            log_mismatch("buzzer_on", int'(out_data.buzzer_on), int'(want.buzzer_on));
          if (out_data.target_level !== want.target_level)
            log_mismatch("target_level", int'(out_data.target_level),
                         int'(want.target_level));
          if (out_data.heat_state !== want.heat_state)
            log_mismatch("heat_state", int'(out_data.heat_state), int'(want.heat_state));
          if (out_data.heater_status !== want.heater_status)
            log_mismatch("heater_status", int'(out_data.heater_status),
                         int'(want.heater_status));
        end
      end
      if (in_valid && in_ready) due_results.push_back(thermostat_tick(in_data));
    end
    pending = due_results.size();
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level bench for heater_thermostat_controller_core
// Directed ticks at the switch thresholds and field extremes, then six
// register settings with random tick streams shaped around the current
// target, random idle bursts on both sides, one long output hold-off and
// one full drain pause. Checking is done by htc_result_checker.
// ----------------------------------------------------------------------------
module tb;
  import htc_pkg::*;

  localparam int HOLD_CYCLES = 40;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  htc_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  htc_out_t              out_data;

  int fail_count;
  int due_count;

  // idle knobs and hold-off handshake between stimulus and receiver
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_asked;
  int hold_done;

  htc_cfg_t plan;

  heater_thermostat_controller_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  htc_result_checker result_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fails     (fail_count),
    .pending   (due_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // generous hard stop
  initial begin
    #3000000;
    $display("FAIL heater_thermostat_controller_core");
    $finish;
  end

  // Result side. Decides out_ready at falling edges: a requested long
  // hold-off wins, else an occasional idle burst, else ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_done < hold_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // One tick transfer. Called at a falling edge, returns at the falling edge
  // after the transfer. valid is only dropped when a gap is taken, so it is
  // never lowered and raised within one step.
  task automatic send_tick(input htc_in_t item);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every result; extra trailing edges leave the core fully idle.
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    int      phase_len;
    int      tgt_i;
    int      temp_i;
    int      sw_i;
    int      zone;
    int      run_left;
    int      waited;
    int      thr;
    htc_in_t item;

    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_SW_HIGH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_asked = 0;
    hold_done  = 0;
    run_left   = 0;
    zone       = 0;
    sw_i       = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks with reset settings: both sides of each threshold
    // (level changes raise short beeps), field extremes, alternating bits.
    send_tick('{temperature: 8'd0,   switch_reading: 12'd0});
    send_tick('{temperature: 8'd255, switch_reading: 12'd4095});
    send_tick('{temperature: 8'd255, switch_reading: 12'd2596});
    send_tick('{temperature: 8'd0,   switch_reading: 12'd2595});
    send_tick('{temperature: 8'd170, switch_reading: 12'd1096});
    send_tick('{temperature: 8'd85,  switch_reading: 12'd1095});
    send_tick('{temperature: 8'd0,   switch_reading: 12'd4095});
    send_tick('{temperature: 8'd255, switch_reading: 12'd0});
    send_tick('{temperature: 8'd20,  switch_reading: 12'haaa});
    send_tick('{temperature: 8'd38,  switch_reading: 12'h555});
    send_tick('{temperature: 8'd30,  switch_reading: 12'd4094});
    send_tick('{temperature: 8'd1,   switch_reading: 12'd1});

    // The machine starts only after the startup delay, so the first three
    // settings mostly exercise level selection and the short beep timer;
    // the last three exercise the heater machine.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          // mid threshold above high: the high test must win
          plan = '{12'd1000, 12'd3000, 8'd20, 8'd30, 8'd38, 5'd2, 5'd5, 4'd5};
          phase_len = 300;
        end
        1: begin
          plan = '{12'd4095, 12'd0, 8'd255, 8'd0, 8'd128, 5'd31, 5'd31, 4'd15};
          phase_len = 300;
        end
        2: begin
          plan = '{12'd2048, 12'd1024, 8'd40, 8'd90, 8'd200, 5'd3, 5'd4, 4'd2};
          phase_len = 300;
        end
        3: begin
          // zero margins and no debounce: fastest transitions
          plan = '{12'd3000, 12'd1500, 8'd60, 8'd100, 8'd150, 5'd0, 5'd0, 4'd0};
          phase_len = 150;
        end
        4: begin
          plan = '{12'd2596, 12'd1096, 8'd0, 8'd128, 8'd255, 5'd31, 5'd31, 4'd15};
          phase_len = 150;
        end
        default: begin
          plan = CFG_RESET;
          plan.debounce_limit = 4'd1;
          phase_len = 100;
          // closing stretch runs without idle cycles
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
      endcase

      cfg_write <= 1'b1;
      cfg_index <= REG_SW_HIGH;
      cfg_data  <= CFG_DATA_W'(plan.switch_high_threshold);
      @(negedge clk);
      cfg_index <= REG_SW_MID;
      cfg_data  <= CFG_DATA_W'(plan.switch_mid_threshold);
      @(negedge clk);
      cfg_index <= REG_TGT_LOW;
      cfg_data  <= CFG_DATA_W'(plan.target_low);
      @(negedge clk);
      cfg_index <= REG_TGT_MID;
      cfg_data  <= CFG_DATA_W'(plan.target_mid);
      @(negedge clk);
      cfg_index <= REG_TGT_HIGH;
      cfg_data  <= CFG_DATA_W'(plan.target_high);
      @(negedge clk);
      cfg_index <= REG_OFF_MARGIN;
      cfg_data  <= CFG_DATA_W'(plan.off_margin);
      @(negedge clk);
      cfg_index <= REG_RHT_MARGIN;
      cfg_data  <= CFG_DATA_W'(plan.reheat_margin);
      @(negedge clk);
      cfg_index <= REG_DEB_LIMIT;
      cfg_data  <= CFG_DATA_W'(plan.debounce_limit);
      @(negedge clk);
      cfg_write <= 1'b0;

      // long result hold-off while ticks keep coming: the core must stall
      if (p == 1) hold_asked++;

      for (int i = 0; i < phase_len; i++) begin
        // sender pause until every result is back
        if (p == 2 && i == 150) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (due_count != 0);
        end

        // switch mostly held, now and then moved to random or to a threshold
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            sw_i = int'($urandom_range(0, 4095));
          end else begin
            thr = ($urandom_range(0, 1) == 0) ? int'(plan.switch_high_threshold)
                                              : int'(plan.switch_mid_threshold);
            sw_i = thr + int'($urandom_range(0, 2)) - 1;
            if (sw_i < 0) sw_i = 0;
            if (sw_i > 4095) sw_i = 4095;
          end
        end
        if (sw_i >= int'(plan.switch_high_threshold)) tgt_i = int'(plan.target_high);
        else if (sw_i >= int'(plan.switch_mid_threshold)) tgt_i = int'(plan.target_mid);
        else tgt_i = int'(plan.target_low);

        // runs of ticks in one temperature band, long enough to sometimes
        // complete a debounce and sometimes break it
        if (run_left == 0) begin
          zone = $urandom_range(0, 9);
          run_left = $urandom_range(1, int'(plan.debounce_limit) + 3);
        end
        run_left--;

        item.switch_reading = sw_i[SW_W-1:0];
        case (zone)
          0: begin
            temp_i = int'($urandom_range(0, 255));
            item.switch_reading = SW_W'($urandom_range(0, 4095));
          end
          1, 2, 3: temp_i = tgt_i - int'(plan.reheat_margin) - int'($urandom_range(0, 3));
          4, 5, 6: temp_i = tgt_i + int'(plan.off_margin) + int'($urandom_range(0, 3));
          7, 8: begin
            temp_i = tgt_i - int'(plan.reheat_margin)
                   + int'($urandom_range(0, int'(plan.reheat_margin) + int'(plan.off_margin)));
          end
          default: temp_i = tgt_i;
        endcase
        if (temp_i < 0) temp_i = 0;
        if (temp_i > 255) temp_i = 255;
        item.temperature = temp_i[TEMP_W-1:0];

        send_tick(item);
      end
    end

    // final drain, bounded; anything still expected counts against the run
    in_valid <= 1'b0;
    for (waited = 0; waited < 5000 && due_count != 0; waited++) @(negedge clk);
    repeat (3) @(negedge clk);

    if (fail_count == 0 && due_count == 0) begin
      $display("PASS heater_thermostat_controller_core");
    end else begin
      $display("FAIL heater_thermostat_controller_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/htc_pkg.sv
rtl/core/htc_step.sv
rtl/core/heater_thermostat_controller_core.sv
rtl/core/htc_checker.sv
sim/htc_result_checker.sv
sim/tb.sv
